@@ hdl/assert_macros.svh @@
// Assertion macros used by the controller of the bounded PCG32 generator.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed in bounded PCG32 generator");

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed in bounded PCG32 generator");

`endif

@@ hdl/pcg32br_pkg.sv @@
// Types and constants shared by the bounded PCG32 generator.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pcg32br_pkg;

    // Request and result payloads.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] range_low;
        logic [31:0] range_high;
    } t_in_req;

    typedef struct packed {
        logic [31:0] value;
        logic [23:0] fraction;
        logic        range_error;
    } t_out_res;

    // Action codes.
    localparam logic [1:0] ACT_RAW     = 2'd0;
    localparam logic [1:0] ACT_BOUNDED = 2'd1;
    localparam logic [1:0] ACT_RESEED  = 2'd2;

    // Configuration register indices.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM = 1'b1;

    // Generator constants.
    localparam logic [63:0] LCG_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] STATE_RESET = 64'h5851_F42D_4C95_7F2E;
    localparam logic [63:0] INC_RESET   = 64'd1;

    // Datapath operations issued by the controller.
    typedef logic [3:0] t_dp_op;
    localparam t_dp_op OP_NONE     = 4'd0;
    localparam t_dp_op OP_RESEED   = 4'd1;
    localparam t_dp_op OP_MUL0     = 4'd2;
    localparam t_dp_op OP_MUL1     = 4'd3;
    localparam t_dp_op OP_MUL2     = 4'd4;
    localparam t_dp_op OP_MUL3     = 4'd5;
    localparam t_dp_op OP_LIM_INIT = 4'd6;
    localparam t_dp_op OP_MOD_INIT = 4'd7;
    localparam t_dp_op OP_DIV_STEP = 4'd8;
    localparam t_dp_op OP_FINISH   = 4'd9;

    typedef struct packed {
        logic   load;   // capture the request being accepted
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       span_zero;
        logic       word_ge_limit;
    } t_dp_status;

endpackage

@@ hdl/pcg32_bounded_random_generator_top.sv @@
// Top level of the bounded PCG32 generator: joins the controller and the datapath.
// Depends on pcg32br_pkg, pcg32br_ctrl and pcg32br_datapath.
`timescale 1ns / 1ps

// Channel    Direction  Handshake                  Payload
// request    in         i_in_valid / o_in_ready    i_in  (action, range_low, range_high)
// result     out        o_out_valid / i_out_ready  o_out (value, fraction, range_error)
// config     in         i_cfg_we                   i_cfg_idx, i_cfg_wdata (64 bits)
//
// A raw draw or a reseed makes one advance of the state before its result; a bounded
// draw divides for the rejection limit, advances for its first word and again for each
// rejected word, then divides for the remainder; a zero range or the unused action
// goes straight to the result. The advance is split into partial products on one
// shared 32 x 32 multiplier; the radix-2 divider yields the limit and the remainder.
// Reset is synchronous and active low; it reloads the state seeded with seed 0 and
// stream 0, clears both configuration registers and clears the result-valid flag.
// A new request is taken as soon as the controller is idle, even while the previous
// result still waits; a finished result then holds until the result register is free.

module pcg32_bounded_random_generator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  pcg32br_pkg::t_in_req              i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output pcg32br_pkg::t_out_res             o_out,
    input  logic                              i_cfg_we,
    input  logic [pcg32br_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                       i_cfg_wdata
);

    // Command and status between the sequencer and the arithmetic.
    pcg32br_pkg::t_dp_cmd    dp_cmd;
    pcg32br_pkg::t_dp_status dp_status;

    // The controller owns both handshakes and the result-valid flag.
    pcg32br_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the generator state, configuration and the result register.
    pcg32br_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_res       (o_out)
    );

endmodule

@@ hdl/pcg32br_datapath.sv @@
// Datapath of the bounded PCG32 generator: state, shared multiplier, divider, result.
// Depends on pcg32br_pkg; driven by pcg32br_ctrl through command and status structs.
`timescale 1ns / 1ps

module pcg32br_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pcg32br_pkg::t_in_req             i_in,
    input  logic                             i_cfg_we,
    input  logic [pcg32br_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                      i_cfg_wdata,
    input  pcg32br_pkg::t_dp_cmd             i_cmd,
    output pcg32br_pkg::t_dp_status          o_status,
    output pcg32br_pkg::t_out_res            o_res
);

    logic [63:0] r_seed;
    logic [62:0] r_stream;
    logic [63:0] r_state;
    logic [63:0] r_inc;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [31:0] r_word;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    pcg32br_pkg::t_in_req  r_req;
    pcg32br_pkg::t_out_res r_res;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] span;
    logic [32:0] trial;
    logic [63:0] new_inc;

    // XSH-RR output permutation of the state before the advance.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] mixed;
        logic [63:0] dbl;
        x     = (s >> 18) ^ s;
        mixed = x[58:27];
        dbl   = {mixed, mixed} >> s[63:59];
        return dbl[31:0];
    endfunction

    assign span    = r_req.range_high - r_req.range_low;
    assign new_inc = {r_stream, 1'b1};
    assign trial   = {r_rem, r_dvd[31]} - {1'b0, span};

    always_comb begin
        mul_a = r_state[31:0];
        mul_b = pcg32br_pkg::LCG_MULT[31:0];
        case (i_cmd.op)
            pcg32br_pkg::OP_MUL1: begin
                mul_a = r_state[63:32];
            end
            pcg32br_pkg::OP_MUL2: begin
                mul_b = pcg32br_pkg::LCG_MULT[63:32];
            end
            default: begin
                mul_a = r_state[31:0];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_stream <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pcg32br_pkg::REG_SEED) begin
                r_seed <= i_cfg_wdata;
            end else begin
                r_stream <= i_cfg_wdata[62:0];
            end
        end
    end

    // Generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcg32br_pkg::STATE_RESET;
            r_inc   <= pcg32br_pkg::INC_RESET;
        end else begin
            case (i_cmd.op)
                pcg32br_pkg::OP_RESEED: begin
                    // The first advance from a zero state yields the increment itself.
                    r_inc   <= new_inc;
                    r_state <= new_inc + r_seed;
                end
                pcg32br_pkg::OP_MUL3: begin
                    r_state <= {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                end
                default: begin
                    r_state <= r_state;
                end
            endcase
        end
    end

    // Payload registers: request, products, divider and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in;
        end
        case (i_cmd.op)
            pcg32br_pkg::OP_MUL0: begin
                r_word <= xsh_rr(r_state);
                r_prod <= mul_p;
            end
            pcg32br_pkg::OP_MUL1: begin
                r_acc  <= r_inc + r_prod;
                r_prod <= mul_p;
            end
            pcg32br_pkg::OP_MUL2: begin
                r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                r_prod       <= mul_p;
            end
            pcg32br_pkg::OP_LIM_INIT: begin
                r_rem <= '0;
                r_dvd <= 32'd0 - span;
            end
            pcg32br_pkg::OP_MOD_INIT: begin
                r_rem <= '0;
                r_dvd <= r_word;
            end
            pcg32br_pkg::OP_DIV_STEP: begin
                r_dvd <= {r_dvd[30:0], 1'b0};
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                end else begin
                    r_rem <= {r_rem[30:0], r_dvd[31]};
                end
            end
            pcg32br_pkg::OP_FINISH: begin
                case (r_req.action)
                    pcg32br_pkg::ACT_RAW: begin
                        r_res <= {r_word, r_word[31:8], 1'b0};
                    end
                    pcg32br_pkg::ACT_BOUNDED: begin
                        if (span == 32'd0) begin
                            r_res <= {r_req.range_low, 24'd0, 1'b1};
                        end else begin
                            r_res <= {r_req.range_low + r_rem, 24'd0, 1'b0};
                        end
                    end
                    default: begin
                        r_res <= '0;
                    end
                endcase
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // While drawing, r_rem still holds the rejection limit.
    assign o_status.action        = r_req.action;
    assign o_status.span_zero     = (span == 32'd0);
    assign o_status.word_ge_limit = (r_word >= r_rem);
    assign o_res                  = r_res;

endmodule

@@ hdl/pcg32br_ctrl.sv @@
// Controller of the bounded PCG32 generator: sequences advances, divisions and results.
// Depends on pcg32br_pkg and assert_macros.svh; commands pcg32br_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcg32br_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  pcg32br_pkg::t_dp_status    i_status,
    output pcg32br_pkg::t_dp_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_MUL      = 3'd2;
    localparam logic [2:0] S_LIMDIV   = 3'd3;
    localparam logic [2:0] S_CHECK    = 3'd4;
    localparam logic [2:0] S_MODDIV   = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [4:0] r_cnt;
    logic [4:0] n_cnt;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_fire;
    logic       out_free;

    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.load  = in_fire;
        o_cmd.op    = pcg32br_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_cnt = '0;
                case (i_status.action)
                    pcg32br_pkg::ACT_RAW: begin
                        n_state = S_MUL;
                    end
                    pcg32br_pkg::ACT_RESEED: begin
                        o_cmd.op = pcg32br_pkg::OP_RESEED;
                        n_state  = S_MUL;
                    end
                    pcg32br_pkg::ACT_BOUNDED: begin
                        if (i_status.span_zero) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.op = pcg32br_pkg::OP_LIM_INIT;
                            n_state  = S_LIMDIV;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_MUL: begin
                n_cnt = r_cnt + 5'd1;
                case (r_cnt[1:0])
                    2'd0: begin
                        o_cmd.op = pcg32br_pkg::OP_MUL0;
                    end
                    2'd1: begin
                        o_cmd.op = pcg32br_pkg::OP_MUL1;
                    end
                    2'd2: begin
                        o_cmd.op = pcg32br_pkg::OP_MUL2;
                    end
                    default: begin
                        o_cmd.op = pcg32br_pkg::OP_MUL3;
                        n_cnt    = '0;
                        if (i_status.action == pcg32br_pkg::ACT_BOUNDED) begin
                            n_state = S_CHECK;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                endcase
            end
            S_LIMDIV: begin
                o_cmd.op = pcg32br_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_MUL;
                end
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_status.word_ge_limit) begin
                    o_cmd.op = pcg32br_pkg::OP_MOD_INIT;
                    n_state  = S_MODDIV;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MODDIV: begin
                o_cmd.op = pcg32br_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.op    = pcg32br_pkg::OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_CLK(a_accept_dispatch, in_fire |=> (r_state == S_DISPATCH))
    `ASSERT_CLK(a_finish_shows, (r_state == S_FINISH && !r_out_valid) |=> r_out_valid)
    `ASSERT_ALWAYS(a_mul_cnt_small, (r_state == S_MUL) |-> (r_cnt[4:2] == 3'd0))
    `ASSERT_CLK(a_mod_from_zero,
        (r_state == S_CHECK && i_status.word_ge_limit) |=> (r_state == S_MODDIV && r_cnt == 5'd0))

endmodule
